@@ rtl/core/hgph_pkg.sv @@
// shared types and constants for the hex grid point hit test
package hgph_pkg;

    // field widths
    localparam int COORD_W  = 18;
    localparam int SIDE_W   = 6;
    localparam int RADIUS_W = 16;
    localparam int CELL_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 18;

    // board size limit default
    localparam int MAX_SIDE_DEF = 32;

    // sqrt(3)/2 in Q1.15 and the products built on it
    localparam int SQRT3_HALF_Q15 = 28378;
    localparam int SK_W = RADIUS_W + 15;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_SIDE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CIRCUMRADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 2'd3;

    // configuration reset values
    localparam logic [SIDE_W-1:0]   RST_BOARD_SIDE   = 6'd11;
    localparam logic [RADIUS_W-1:0] RST_CIRCUMRADIUS = 16'd512;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // latch query point on input transfer
        logic setup;    // clear walk counters and candidate
        logic step;     // issue one cell into the distance pipe
        logic test;     // first step of the containment test
        logic finish;   // load result register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic side_zero;
        logic last_cell;
        logic pipe_busy;
    } t_status;

endpackage

@@ rtl/core/hex_grid_point_hit_test.sv @@
// one point at a time: a new point is taken only once the last one has loaded its result;
// the distance walk issues one cell per cycle; a point is taken while the last result waits
// reset: synchronous active low; clears control state and loads configuration
// defaults (side 11, circumradius 512, origin 0)
module hex_grid_point_hit_test #(
    parameter int MAX_SIDE = hgph_pkg::MAX_SIDE_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [hgph_pkg::COORD_W-1:0]   i_point_x,
    input  logic signed [hgph_pkg::COORD_W-1:0]   i_point_y,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_hit,
    output logic [hgph_pkg::CELL_W-1:0]           o_cell_row,
    output logic [hgph_pkg::CELL_W-1:0]           o_cell_col,
    input  logic                                  i_cfg_we,
    input  logic [hgph_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [hgph_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import hgph_pkg::*;

    logic [SIDE_W-1:0]          r_board_side;
    logic [RADIUS_W-1:0]        r_circumradius;
    logic signed [COORD_W-1:0]  r_origin_x, r_origin_y;
    t_cmd                       cmd;
    t_status                    status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_side   <= RST_BOARD_SIDE;
            r_circumradius <= RST_CIRCUMRADIUS;
            r_origin_x     <= '0;
            r_origin_y     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BOARD_SIDE:   r_board_side   <= i_cfg_data[SIDE_W-1:0];
                CFG_CIRCUMRADIUS: r_circumradius <= i_cfg_data[RADIUS_W-1:0];
                CFG_ORIGIN_X:     r_origin_x     <= i_cfg_data[COORD_W-1:0];
                CFG_ORIGIN_Y:     r_origin_y     <= i_cfg_data[COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // controller
    hgph_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // datapath
    hgph_dpath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_board_side   (r_board_side),
        .i_circumradius (r_circumradius),
        .i_origin_x     (r_origin_x),
        .i_origin_y     (r_origin_y),
        .o_hit          (o_hit),
        .o_cell_row     (o_cell_row),
        .o_cell_col     (o_cell_col)
    );

endmodule

@@ rtl/core/hgph_ctrl.sv @@
// controller state machine for the hex grid point hit test
module hgph_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output hgph_pkg::t_cmd    o_cmd,
    input  hgph_pkg::t_status i_status
);
    import hgph_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SETUP  = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_TEST   = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = i_status.side_zero ? S_TEST : S_WALK;
            end
            S_WALK: begin
                o_cmd.step = 1'b1;
                if (i_status.last_cell) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                o_cmd.test = 1'b1;
                n_state    = S_FINISH;
            end
            S_FINISH: begin
                if (slot_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result slot valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/core/hgph_dpath.sv @@
// datapath: cell walk, distance pipe, nearest tracking and hexagon test
module hgph_dpath #(
    parameter int MAX_SIDE = hgph_pkg::MAX_SIDE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hgph_pkg::t_cmd                      i_cmd,
    output hgph_pkg::t_status                   o_status,
    input  logic signed [hgph_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [hgph_pkg::COORD_W-1:0] i_point_y,
    input  logic [hgph_pkg::SIDE_W-1:0]         i_board_side,
    input  logic [hgph_pkg::RADIUS_W-1:0]       i_circumradius,
    input  logic signed [hgph_pkg::COORD_W-1:0] i_origin_x,
    input  logic signed [hgph_pkg::COORD_W-1:0] i_origin_y,
    output logic                                o_hit,
    output logic [hgph_pkg::CELL_W-1:0]         o_cell_row,
    output logic [hgph_pkg::CELL_W-1:0]         o_cell_col
);
    import hgph_pkg::*;

    localparam int IDXW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int NW   = $clog2(MAX_SIDE + 1);
    localparam int CW   = NW + 1;
    localparam int MW   = $clog2(3 * MAX_SIDE);
    localparam int TW   = SK_W + MW;
    localparam int CXW  = TW - 14;
    localparam int CYW  = RADIUS_W + 2 + IDXW;
    localparam int QW   = COORD_W + 1;
    localparam int DW0  = (CXW > QW) ? CXW : QW;
    localparam int DW   = ((CYW - 1 > DW0) ? CYW - 1 : DW0) + 1;
    localparam int SQW  = 2 * DW - 1;
    localparam int D2W  = 2 * DW;
    localparam int PW   = DW + 18;
    localparam logic signed [16:0] K_S = 17'(SQRT3_HALF_Q15);

    // query point relative to the board origin
    logic signed [QW-1:0] r_qx, r_qy;

    // per-item constants
    logic [SK_W-1:0]       r_sk;
    logic [RADIUS_W+1:0]   r_s3;
    logic [NW-1:0]         r_n;

    // walk counters
    logic [IDXW-1:0] r_row, r_col;
    logic [TW-1:0]   r_t, r_t_row;
    logic [CYW-1:0]  r_cy;
    logic            col_last, row_last;

    // distance pipe
    logic                   r_v1, r_v2;
    logic signed [DW-1:0]   r_dx1, r_dy1, r_dx2, r_dy2;
    logic [IDXW-1:0]        r_row1, r_col1, r_row2, r_col2;
    logic [SQW-1:0]         r_sqx, r_sqy;
    logic [TW:0]            t_round;
    logic [CXW-1:0]         cx_off;
    logic signed [2*DW-1:0] sq_x, sq_y;
    logic [D2W-1:0]         d2;

    // nearest candidate
    logic                 r_have;
    logic [D2W-1:0]       r_best_d2;
    logic signed [DW-1:0] r_best_dx, r_best_dy;
    logic [IDXW-1:0]      r_best_r, r_best_c;

    // containment test
    logic signed [DW+16:0] r_dyk;
    logic [SK_W:0]         h_sum;
    logic [16:0]           h;
    logic [17:0]           lim;
    logic signed [PW-1:0]  dx_sh, p60, p120;
    logic [PW-1:0]         a60, a120, adx, lim_p, lim_d;
    logic                  hit;

    // status
    assign col_last = (CW'(r_col) + CW'(1)) == CW'(r_n);
    assign row_last = (CW'(r_row) + CW'(1)) == CW'(r_n);
    assign o_status.side_zero = (i_board_side == '0);
    assign o_status.last_cell = col_last && row_last;
    assign o_status.pipe_busy = r_v1 || r_v2;

    // latch query point
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_qx <= QW'(i_point_x) - QW'(i_origin_x);
            r_qy <= QW'(i_point_y) - QW'(i_origin_y);
        end
    end

    // setup constants and walk counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_sk <= SK_W'(i_circumradius * 15'(SQRT3_HALF_Q15));
            r_s3 <= (RADIUS_W+2)'({i_circumradius, 1'b0}) + (RADIUS_W+2)'(i_circumradius);
            r_n  <= (int'(i_board_side) > MAX_SIDE) ? NW'(MAX_SIDE) : NW'(i_board_side);
            r_row   <= '0;
            r_col   <= '0;
            r_t     <= '0;
            r_t_row <= '0;
            r_cy    <= '0;
        end else if (i_cmd.step) begin
            if (col_last) begin
                r_col   <= '0;
                r_row   <= r_row + IDXW'(1);
                r_t_row <= r_t_row + TW'(r_sk);
                r_t     <= r_t_row + TW'(r_sk);
                r_cy    <= r_cy + CYW'(r_s3);
            end else begin
                r_col <= r_col + IDXW'(1);
                r_t   <= r_t + TW'({r_sk, 1'b0});
            end
        end
    end

    // stage one: offsets from the cell centre
    assign t_round = (TW+1)'(r_t) + (TW+1)'(2**14);
    assign cx_off  = t_round[TW:15];

    always_ff @(posedge i_clk) begin
        r_dx1  <= DW'(r_qx) - DW'(cx_off);
        r_dy1  <= DW'(r_qy) - DW'(r_cy[CYW-1:1]);
        r_row1 <= r_row;
        r_col1 <= r_col;
    end

    // stage two: squares
    assign sq_x = r_dx1 * r_dx1;
    assign sq_y = r_dy1 * r_dy1;

    always_ff @(posedge i_clk) begin
        r_sqx  <= sq_x[SQW-1:0];
        r_sqy  <= sq_y[SQW-1:0];
        r_dx2  <= r_dx1;
        r_dy2  <= r_dy1;
        r_row2 <= r_row1;
        r_col2 <= r_col1;
    end

    // pipe valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.step;
            r_v2 <= r_v1;
        end
    end

    // stage three: keep the first nearest centre
    assign d2 = D2W'(r_sqx) + D2W'(r_sqy);

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_have    <= 1'b0;
            r_best_d2 <= '0;
            r_best_dx <= DW'(r_qx);
            r_best_dy <= DW'(r_qy);
            r_best_r  <= '0;
            r_best_c  <= '0;
        end else if (r_v2 && (!r_have || d2 < r_best_d2)) begin
            r_have    <= 1'b1;
            r_best_d2 <= d2;
            r_best_dx <= r_dx2;
            r_best_dy <= r_dy2;
            r_best_r  <= r_row2;
            r_best_c  <= r_col2;
        end
    end

    // containment: dy times sqrt(3)/2
    always_ff @(posedge i_clk) begin
        if (i_cmd.test) begin
            r_dyk <= r_best_dy * K_S;
        end
    end

    // inradius and limit with tolerance
    assign h_sum = (SK_W+1)'(r_sk) + (SK_W+1)'(2**14);
    assign h     = 17'(h_sum[SK_W:15]);
    assign lim   = 18'(h) + 18'(h >> 13);

    // projections onto the 0, 60 and 120 degree normals
    assign dx_sh = PW'(r_best_dx) <<< 14;
    assign p60   = dx_sh + PW'(r_dyk);
    assign p120  = PW'(r_dyk) - dx_sh;
    assign a60   = (p60 < 0) ? PW'(-p60) : PW'(p60);
    assign a120  = (p120 < 0) ? PW'(-p120) : PW'(p120);
    assign adx   = (r_best_dx < 0) ? PW'(-r_best_dx) : PW'(r_best_dx);
    assign lim_p = PW'(lim) << 15;
    assign lim_d = PW'(lim);
    assign hit   = (adx <= lim_d) && (a60 <= lim_p) && (a120 <= lim_p);

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_hit      <= hit;
            o_cell_row <= hit ? CELL_W'(r_best_r) : '0;
            o_cell_col <= hit ? CELL_W'(r_best_c) : '0;
        end
    end

endmodule

@@ test/tb_hex_grid_point_hit_test.sv @@
`timescale 1ns / 1ps
// testbench for the hex grid point hit test: clicks checked against a nearest-cell predictor
module tb_hex_grid_point_hit_test;
    import hgph_pkg::*;

    localparam int     BOARD_MAX    = 32;
    localparam longint ROOT3_HALF   = 28378;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     DRAIN_CYCLES = 1100;
    localparam int     MAX_REPORTS  = 200;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } click_t;

    typedef struct {
        logic              hit;
        logic [CELL_W-1:0] row;
        logic [CELL_W-1:0] col;
    } cell_hit_t;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic signed [COORD_W-1:0]    i_point_x;
    logic signed [COORD_W-1:0]    i_point_y;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic                         o_hit;
    logic [CELL_W-1:0]            o_cell_row;
    logic [CELL_W-1:0]            o_cell_col;
    logic                         i_cfg_we;
    logic [CFG_IDX_W-1:0]         i_cfg_idx;
    logic [CFG_DATA_W-1:0]        i_cfg_data;

    // local copy of the board registers, reset values
    int     board_n_cfg = 11;
    longint radius_cfg  = 512;
    longint orig_x_cfg  = 0;
    longint orig_y_cfg  = 0;

    click_t    clicks_to_send[$];
    cell_hit_t cell_hits_due[$];
    click_t    next_click;
    cell_hit_t want;

    int   clicks_queued  = 0;
    int   clicks_taken   = 0;
    int   bad_count      = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic in_took;
    logic hold_arm;
    logic rx_hold;

    hex_grid_point_hit_test #(
        .MAX_SIDE(BOARD_MAX)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_hit       (o_hit),
        .o_cell_row  (o_cell_row),
        .o_cell_col  (o_cell_col),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cell centre positions at the current board setting
    function automatic longint cell_cx(input int r, input int c);
        return orig_x_cfg + ((radius_cfg * ROOT3_HALF * (2 * c + r) + 16384) >>> 15);
    endfunction

    function automatic longint cell_cy(input int r);
        return orig_y_cfg + ((3 * radius_cfg * r) >>> 1);
    endfunction

    // inradius plus its small tolerance
    function automatic longint hex_limit();
        longint h;
        h = (radius_cfg * ROOT3_HALF + 16384) >>> 15;
        return h + (h >>> 13);
    endfunction

    function automatic longint mag(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // nearest centre in row-major order, first minimum kept, then the hexagon test
    function automatic cell_hit_t locate_cell(input logic signed [COORD_W-1:0] px_in, py_in);
        longint    px, py, dx, dy, d2, best_d2, lim;
        int        n, r, c, best_r, best_c;
        cell_hit_t res;
        px      = px_in;
        py      = py_in;
        n       = board_n_cfg > BOARD_MAX ? BOARD_MAX : board_n_cfg;
        best_r  = 0;
        best_c  = 0;
        best_d2 = 0;
        for (r = 0; r < n; r++) begin
            for (c = 0; c < n; c++) begin
                dx = px - cell_cx(r, c);
                dy = py - cell_cy(r);
                d2 = dx * dx + dy * dy;
                if ((r == 0 && c == 0) || d2 < best_d2) begin
                    best_d2 = d2;
                    best_r  = r;
                    best_c  = c;
                end
            end
        end
        dx  = px - cell_cx(best_r, best_c);
        dy  = py - cell_cy(best_r);
        lim = hex_limit() * 32768;
        res.hit = mag(dx * 32768) <= lim
               && mag(dx * 16384 + dy * ROOT3_HALF) <= lim
               && mag(dy * ROOT3_HALF - dx * 16384) <= lim;
        res.row = res.hit ? best_r[CELL_W-1:0] : '0;
        res.col = res.hit ? best_c[CELL_W-1:0] : '0;
        return res;
    endfunction

    // sender: offer the next click and hold it until the transfer
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_took) begin
            if (clicks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_click = clicks_to_send.pop_front();
                i_in_valid <= 1'b1;
                i_point_x  <= next_click.x;
                i_point_y  <= next_click.y;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // input transfers: predict the result of each accepted click
    always @(posedge i_clk) begin
        in_took <= i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            cell_hits_due.push_back(locate_cell(i_point_x, i_point_y));
            clicks_taken++;
        end
    end

    // receiver: random stalls, plus the long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        rx_hold = 1'b0;
        wait (hold_arm);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic check_field(input string name, input logic [CELL_W-1:0] exp_v, got_v);
        if (got_v !== exp_v) begin
            bad_count++;
            if (bad_count <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                         got_v);
            end
        end
    endtask

    // output transfers: compare with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cell_hits_due.size() == 0) begin
                bad_count++;
                if (bad_count <= MAX_REPORTS) begin
                    $display("%0t: result with none expected, expected nothing, actual %0d %0d %0d",
                             $time, o_hit, o_cell_row, o_cell_col);
                end
            end else begin
                want = cell_hits_due.pop_front();
                check_field("hit", want.hit, o_hit);
                check_field("cell_row", want.row, o_cell_row);
                check_field("cell_col", want.col, o_cell_col);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic load_board(input int side, input longint radius, ox, oy);
        write_reg(CFG_BOARD_SIDE, side);
        write_reg(CFG_CIRCUMRADIUS, radius);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        board_n_cfg = side;
        radius_cfg  = radius;
        orig_x_cfg  = ox;
        orig_y_cfg  = oy;
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
        endcase
    endtask

    task automatic add_click(input longint x, y);
        click_t item;
        item.x = x[COORD_W-1:0];
        item.y = y[COORD_W-1:0];
        clicks_to_send.push_back(item);
        clicks_queued++;
    endtask

    // all queued clicks transferred and all results back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (clicks_taken != clicks_queued || cell_hits_due.size() != 0);
    endtask

    // random clicks: mostly near cell centres, some on shared edges and hexagon limits
    task automatic queue_clicks(input int count);
        int     n, k, r, c, r2, c2, pick;
        longint span, lim, cx, cy, px, py;
        n    = board_n_cfg > BOARD_MAX ? BOARD_MAX : board_n_cfg;
        n    = n < 1 ? 1 : n;
        span = radius_cfg > 4 ? radius_cfg : 4;
        lim  = hex_limit();
        for (k = 0; k < count; k++) begin
            r    = $urandom_range(n - 1);
            c    = $urandom_range(n - 1);
            cx   = cell_cx(r, c);
            cy   = cell_cy(r);
            pick = $urandom_range(19);
            if (pick < 12) begin
                px = cx + longint'($urandom_range(2 * span)) - span;
                py = cy + longint'($urandom_range(2 * span)) - span;
            end else if (pick < 15) begin
                // midpoint to a neighbour: ties and shared edges
                r2 = r;
                c2 = c;
                case ($urandom_range(5))
                    0: c2 = c + 1;
                    1: c2 = c - 1;
                    2: r2 = r + 1;
                    3: r2 = r - 1;
                    4: begin r2 = r + 1; c2 = c - 1; end
                    default: begin r2 = r - 1; c2 = c + 1; end
                endcase
                if (r2 < 0 || r2 >= n || c2 < 0 || c2 >= n) begin
                    r2 = r;
                    c2 = c;
                end
                px = ((cx + cell_cx(r2, c2)) >>> 1) + longint'($urandom_range(2)) - 1;
                py = ((cy + cell_cy(r2)) >>> 1) + longint'($urandom_range(2)) - 1;
            end else if (pick < 17) begin
                // just on or just past the flat sides and the pointy vertices
                if ($urandom_range(1) != 0) begin
                    px = cx + ($urandom_range(1) != 0 ? 1 : -1)
                              * (lim + longint'($urandom_range(1)));
                    py = cy;
                end else begin
                    px = cx;
                    py = cy + ($urandom_range(1) != 0 ? 1 : -1)
                              * (radius_cfg + longint'($urandom_range(1)));
                end
            end else begin
                px = $urandom;
                py = $urandom;
            end
            add_click(px, py);
        end
    endtask

    task automatic board_phase(input int side, input longint radius, ox, oy,
                               input int count, input int mode);
        load_board(side, radius, ox, oy);
        set_idle(mode);
        queue_clicks(count);
        wait_drained();
    endtask

    // time limit
    initial begin
        #5_000_000;
        $display("tb_hex_grid_point_hit_test NOT OK");
        $finish;
    end

    // main sequence
    initial begin
        int k;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_point_x  = '0;
        i_point_y  = '0;
        i_out_ready = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_BOARD_SIDE;
        i_cfg_data = '0;
        in_took    = 1'b0;
        hold_arm   = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset board: centres, far corners of the point range, hexagon limits
        set_idle(0);
        add_click(cell_cx(0, 0), cell_cy(0));
        add_click(cell_cx(10, 10), cell_cy(10));
        add_click(cell_cx(5, 7), cell_cy(5));
        add_click(-131072, -131072);
        add_click(131071, 131071);
        add_click(-131072, 131071);
        add_click(131071, -131072);
        add_click(hex_limit(), 0);
        add_click(hex_limit() + 1, 0);
        add_click(0, -512);
        add_click(0, -511);
        wait_drained();

        // tiny cells: equal distance to two centres, first one wins
        load_board(3, 16, 0, 0);
        add_click(14, 0);
        add_click(13, 0);
        add_click(-14, 0);
        wait_drained();

        // largest radius: points inside the tolerance band past the inradius
        load_board(1, 65535, 0, 0);
        add_click(hex_limit(), 0);
        add_click(hex_limit() + 1, 0);
        add_click(hex_limit() - 3, 0);
        add_click(-hex_limit(), 0);
        wait_drained();

        // empty board keeps cell zero zero
        load_board(0, 512, 0, 0);
        add_click(0, 0);
        add_click(2000, 0);
        wait_drained();

        // side beyond the limit saturates
        load_board(63, 16, -131072, -131072);
        add_click(cell_cx(31, 31), cell_cy(31));
        add_click(131071, 131071);
        wait_drained();

        // zero radius: every centre on the origin
        load_board(2, 0, 131071, 131071);
        add_click(131071, 131071);
        add_click(131070, 131071);
        wait_drained();

        // random phases over several board settings and idle patterns
        board_phase(11, 512, 0, 0, 60, 1);
        board_phase(1, 65535, 131071, -131072, 50, 2);
        board_phase(2, 0, -131072, 131071, 40, 3);

        // receiver holds off while clicks keep coming
        load_board(4, 300, -5000, 7000);
        set_idle(0);
        hold_arm = 1'b1;
        queue_clicks(60);
        wait_drained();

        board_phase(32, 100, 1234, -4321, 15, 1);
        board_phase(63, 16, -131072, -131072, 15, 2);
        board_phase(0, 1000, 500, -500, 30, 3);
        board_phase(6, 15, -20000, 20000, 60, 0);
        board_phase(8, 2000, -30000, -20000, 60, 1);
        board_phase(5, 12000, -100000, -100000, 60, 2);
        for (k = 0; k < 4; k++) begin
            board_phase($urandom_range(1, 7), $urandom_range(16, 6000),
                        longint'($urandom_range(262143)) - 131072,
                        longint'($urandom_range(262143)) - 131072, 30, (k + 3) % 4);
        end

        // let any stray result show up
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (bad_count == 0 && cell_hits_due.size() == 0) begin
            $display("tb_hex_grid_point_hit_test OK");
        end else begin
            $display("tb_hex_grid_point_hit_test NOT OK");
        end
        $finish;
    end

endmodule
